// File: hw/rtl/tjpg_pkg.sv
package tjpg_pkg;

    localparam int JOINTS = 3;
    localparam int JW     = 2;   // joint index width
    localparam int AW     = 16;  // angle width
    localparam int EW     = 17;  // error width
    localparam int DW     = 13;  // duty width
    localparam int MCW    = 16;  // multiplicand width
    localparam int MPW    = 32;  // multiplier width, one bit per cycle
    localparam int PW     = MCW + MPW;

    // register indexes
    localparam logic [2:0] REG_IR_THR    = 3'd0;
    localparam logic [2:0] REG_FORCE_THR = 3'd1;
    localparam logic [2:0] REG_BAND      = 3'd2;
    localparam logic [2:0] REG_PERIOD    = 3'd3;
    localparam logic [2:0] REG_OPEN      = 3'd4;
    localparam logic [2:0] REG_CLOSE     = 3'd5;
    localparam logic [2:0] REG_STEP      = 3'd6;

    // direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // lamp codes
    localparam logic [1:0] LAMP_OFF   = 2'd0;
    localparam logic [1:0] LAMP_RED   = 2'd1;
    localparam logic [1:0] LAMP_GREEN = 2'd2;

    typedef struct packed {
        logic             start;
        logic [MCW-1:0]   mcand;
        logic [MPW-1:0]   mplier;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [PW-1:0]    product;
    } mul_rsp_t;

    // approach references, Q9.7 degrees
    function automatic logic signed [EW-1:0] ref_a(input logic [JW-1:0] j);
        unique case (j)
            2'd0:    ref_a = 17'sd3840;
            2'd1:    ref_a = 17'sd5760;
            2'd2:    ref_a = 17'sd11520;
            default: ref_a = '0;
        endcase
    endfunction

    // carry references, Q9.7 degrees
    function automatic logic signed [EW-1:0] ref_b(input logic [JW-1:0] j);
        unique case (j)
            2'd0:    ref_b = 17'sd3840;
            2'd1:    ref_b = -17'sd5760;
            2'd2:    ref_b = 17'sd8960;
            default: ref_b = '0;
        endcase
    endfunction

    // gains, Q8.8
    function automatic logic [MCW-1:0] kp_a(input logic [JW-1:0] j);
        unique case (j)
            2'd0:    kp_a = 16'd3840;
            2'd1:    kp_a = 16'd6912;
            2'd2:    kp_a = 16'd1920;
            default: kp_a = '0;
        endcase
    endfunction

    function automatic logic [MCW-1:0] ki_a(input logic [JW-1:0] j);
        unique case (j)
            2'd0:    ki_a = 16'd768;
            2'd1:    ki_a = 16'd2048;
            default: ki_a = '0;
        endcase
    endfunction

    function automatic logic [MCW-1:0] kp_b(input logic [JW-1:0] j);
        unique case (j)
            2'd0:    kp_b = 16'd2560;
            2'd1:    kp_b = 16'd3072;
            2'd2:    kp_b = 16'd3840;
            default: kp_b = '0;
        endcase
    endfunction

endpackage

// File: hw/rtl/three_joint_pi_gripper_controller.sv
// Three-joint PI arm controller with gripper control.
// Input channel s_*: one transfer per control tick carrying three joint
// angles and fresh IR and force samples. Result channel m_*: exactly one
// transfer per tick with the held motor duties, directions, gripper duty
// and lamps. Configuration channel cfg_*: always ready, one register per
// transfer; write only while the block is idle.
// Each tick runs five multiplies per joint on one shift-add multiplier that
// takes one multiplier bit per cycle; each multiply passes through the
// S_START and S_WAIT states, and the result is registered in S_APPLY once
// the last multiply of the last joint is done and the previous result is taken.
// One tick is in work at a time; the next input is taken once the result
// is registered, even while that result still waits on m_tready.
// A stalled receiver holds the result; the block finishes the next tick and
// then waits until the previous result is taken.
// Reset (aresetn low, synchronous) clears integrals, drives, directions and
// lamps, sets the gripper duty to 500 and loads the default registers.
module three_joint_pi_gripper_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // angle_a[15:0] angle_b[31:16] angle_c[47:32] ir_sample[57:48]
    // force_sample[67:58], zero fill above
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // duty_a[12:0] duty_b[25:13] duty_c[38:26] dir_a[40:39] dir_b[42:41]
    // dir_c[44:43] gripper_duty[57:45] lamps[59:58], zero fill above
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_APPLY} state_t;

    localparam int NJ = tjpg_pkg::JOINTS;
    localparam int DW = tjpg_pkg::DW;
    localparam int EW = tjpg_pkg::EW;

    // multiply steps of one joint
    localparam logic [2:0] OP_INC_A  = 3'd0;
    localparam logic [2:0] OP_INC_B  = 3'd1;
    localparam logic [2:0] OP_P_A    = 3'd2;
    localparam logic [2:0] OP_DUTY_A = 3'd3;
    localparam logic [2:0] OP_DUTY_B = 3'd4;

    // configuration
    logic [9:0]    ir_thr_reg, force_thr_reg;
    logic [14:0]   band_reg;
    logic [DW-1:0] period_reg, open_reg, close_reg;
    logic [15:0]   step_reg;

    // tick state
    state_t         state_reg, state_next;
    logic [2:0]     op_reg, op_next;
    logic [1:0]     j_reg, j_next;
    logic [15:0]    ang_reg [NJ];
    logic [9:0]     ir_reg, force_reg;
    logic [9:0]     last_ir_reg, last_ir_next;
    logic [30:0]    sa_reg [NJ];
    logic [30:0]    sa_next [NJ];
    logic signed [31:0] sb_reg [NJ];
    logic signed [31:0] sb_next [NJ];
    logic [28:0]    pa_reg, pa_next;
    logic [DW-1:0]  da_reg [NJ];
    logic [DW-1:0]  da_next [NJ];
    logic [DW-1:0]  db_reg [NJ];
    logic [DW-1:0]  db_next [NJ];
    logic [DW-1:0]  hduty_reg [NJ];
    logic [DW-1:0]  hduty_next [NJ];
    logic [1:0]     hdir_reg [NJ];
    logic [1:0]     hdir_next [NJ];
    logic [DW-1:0]  hgrip_reg, hgrip_next;
    logic [1:0]     hlamp_reg, hlamp_next;
    logic           mvalid_reg, mvalid_next;
    logic [63:0]    mdata_reg, mdata_next;

    tjpg_pkg::mul_req_t req;
    tjpg_pkg::mul_rsp_t rsp;

    tjpg_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // errors of the joint in work
    logic signed [EW-1:0] ea_cur, eb_cur;
    logic [15:0]          mea_cur, meb_cur;
    logic                 s_xfer, load_out;

    always_comb begin
        ea_cur  = tjpg_pkg::ref_a(j_reg) - {ang_reg[j_reg][15], ang_reg[j_reg]};
        eb_cur  = tjpg_pkg::ref_b(j_reg) - {ang_reg[j_reg][15], ang_reg[j_reg]};
        mea_cur = ea_cur[EW-1] ? 16'(-ea_cur) : ea_cur[15:0];
        meb_cur = eb_cur[EW-1] ? 16'(-eb_cur) : eb_cur[15:0];
    end

    // operand select for the shared multiplier
    always_comb begin
        req.start  = (state_reg == S_START);
        req.mcand  = step_reg;
        req.mplier = {16'd0, mea_cur};
        unique case (op_reg)
            OP_INC_A: begin
                req.mcand  = step_reg;
                req.mplier = {16'd0, mea_cur};
            end
            OP_INC_B: begin
                req.mcand  = step_reg;
                req.mplier = {16'd0, meb_cur};
            end
            OP_P_A: begin
                req.mcand  = tjpg_pkg::kp_a(j_reg);
                req.mplier = {16'd0, mea_cur};
            end
            OP_DUTY_A: begin
                req.mcand  = tjpg_pkg::ki_a(j_reg);
                req.mplier = {1'b0, sa_reg[j_reg]};
            end
            default: begin
                req.mcand  = tjpg_pkg::kp_b(j_reg);
                req.mplier = {16'd0, meb_cur};
            end
        endcase
    end

    function automatic logic [DW-1:0] sat_duty(input logic [33:0] q,
                                               input logic [DW-1:0] per);
        sat_duty = (q > {21'd0, per}) ? per : q[DW-1:0];
    endfunction

    // apply-time errors of all joints
    logic signed [EW-1:0] ea_all [NJ];
    logic signed [EW-1:0] eb_all [NJ];
    logic [15:0]          meb1;
    logic                 approach, closing, ir_hit;

    always_comb begin
        for (int k = 0; k < NJ; k++) begin
            ea_all[k] = tjpg_pkg::ref_a(2'(k)) - {ang_reg[k][15], ang_reg[k]};
            eb_all[k] = tjpg_pkg::ref_b(2'(k)) - {ang_reg[k][15], ang_reg[k]};
        end
        meb1     = eb_all[1][EW-1] ? 16'(-eb_all[1]) : eb_all[1][15:0];
        approach = last_ir_reg < ir_thr_reg;
        ir_hit   = ir_reg >= ir_thr_reg;
        closing  = !approach || ir_hit;
    end

    assign s_xfer   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_APPLY) && (!mvalid_reg || m_tready);

    always_comb begin
        logic [32:0] pr;
        logic [31:0] suma;
        logic signed [33:0] delta, sumb;
        logic [48:0] tot;
        pr           = rsp.product[32:0];
        suma         = '0;
        delta        = '0;
        sumb         = '0;
        tot          = '0;
        state_next   = state_reg;
        op_next      = op_reg;
        j_next       = j_reg;
        pa_next      = pa_reg;
        last_ir_next = last_ir_reg;
        hgrip_next   = hgrip_reg;
        hlamp_next   = hlamp_reg;
        mdata_next   = mdata_reg;
        mvalid_next  = mvalid_reg;
        for (int k = 0; k < NJ; k++) begin
            sa_next[k]    = sa_reg[k];
            sb_next[k]    = sb_reg[k];
            da_next[k]    = da_reg[k];
            db_next[k]    = db_reg[k];
            hduty_next[k] = hduty_reg[k];
            hdir_next[k]  = hdir_reg[k];
        end
        // drop the result once taken
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    op_next    = OP_INC_A;
                    j_next     = '0;
                    state_next = S_START;
                end
            end
            S_START: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (rsp.done) begin
                    unique case (op_reg)
                        OP_INC_A: begin
                            suma = {1'b0, sa_reg[j_reg]} + {16'd0, rsp.product[31:16]};
                            sa_next[j_reg] = suma[31] ? 31'h7FFF_FFFF : suma[30:0];
                        end
                        OP_INC_B: begin
                            delta = {18'd0, rsp.product[31:16]};
                            if (eb_cur[EW-1]) begin
                                delta = -delta;
                            end
                            sumb = {{2{sb_reg[j_reg][31]}}, sb_reg[j_reg]} + delta;
                            if (sumb > 34'sh0_7FFF_FFFF) begin
                                sb_next[j_reg] = 32'sh7FFF_FFFF;
                            end else if (sumb < -34'sh0_8000_0000) begin
                                sb_next[j_reg] = -32'sh8000_0000;
                            end else begin
                                sb_next[j_reg] = sumb[31:0];
                            end
                        end
                        OP_P_A: begin
                            pa_next = rsp.product[28:0];
                        end
                        OP_DUTY_A: begin
                            tot = {20'd0, pa_reg} + {1'b0, rsp.product};
                            da_next[j_reg] = sat_duty(tot[48:15], period_reg);
                        end
                        default: begin
                            db_next[j_reg] = sat_duty({16'd0, pr[32:15]}, period_reg);
                        end
                    endcase
                    state_next = S_START;
                    if (op_reg == OP_DUTY_B) begin
                        op_next = OP_INC_A;
                        if (j_reg == 2'(NJ - 1)) begin
                            state_next = S_APPLY;
                        end else begin
                            j_next = j_reg + 2'd1;
                        end
                    end else begin
                        op_next = op_reg + 3'd1;
                    end
                end
            end
            default: begin
                if (load_out) begin
                    // approach phase
                    if (approach) begin
                        for (int k = 0; k < NJ; k++) begin
                            if (ea_all[k] != '0) begin
                                hduty_next[k] = da_reg[k];
                                hdir_next[k]  = ea_all[k][EW-1] ? tjpg_pkg::DIR_REV
                                                                : tjpg_pkg::DIR_FWD;
                            end
                        end
                        hlamp_next = tjpg_pkg::LAMP_GREEN;
                        hgrip_next = '0;
                    end
                    // close check, carry and release
                    if (closing) begin
                        hlamp_next = tjpg_pkg::LAMP_RED;
                        if (force_reg > force_thr_reg) begin
                            hlamp_next = tjpg_pkg::LAMP_OFF;
                            if (eb_all[0] != '0) begin
                                hduty_next[0] = db_reg[0];
                                hdir_next[0]  = eb_all[0][EW-1] ? tjpg_pkg::DIR_REV
                                                                : tjpg_pkg::DIR_FWD;
                                if ({1'b0, meb1} < {2'b0, band_reg}) begin
                                    hgrip_next = open_reg;
                                    for (int k = 0; k < NJ; k++) begin
                                        hduty_next[k] = '0;
                                    end
                                end
                            end
                            for (int k = 1; k < NJ; k++) begin
                                if (eb_all[k] != '0) begin
                                    hduty_next[k] = db_reg[k];
                                    hdir_next[k]  = eb_all[k][EW-1] ? tjpg_pkg::DIR_REV
                                                                    : tjpg_pkg::DIR_FWD;
                                end
                            end
                        end else if (ir_hit && force_reg < force_thr_reg) begin
                            hgrip_next = close_reg;
                        end
                    end
                    last_ir_next = ir_reg;
                    mdata_next   = {4'd0, hlamp_next, hgrip_next,
                                    hdir_next[2], hdir_next[1], hdir_next[0],
                                    hduty_next[2], hduty_next[1], hduty_next[0]};
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        pa_reg <= pa_next;
        for (int k = 0; k < NJ; k++) begin
            da_reg[k] <= da_next[k];
            db_reg[k] <= db_next[k];
        end
        mdata_reg <= mdata_next;
        // capture the tick's input
        if (s_xfer) begin
            ang_reg[0] <= s_tdata[15:0];
            ang_reg[1] <= s_tdata[31:16];
            ang_reg[2] <= s_tdata[47:32];
            ir_reg     <= s_tdata[57:48];
            force_reg  <= s_tdata[67:58];
        end
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_INC_A;
            j_reg         <= '0;
            last_ir_reg   <= '0;
            hgrip_reg     <= 13'd500;
            hlamp_reg     <= tjpg_pkg::LAMP_OFF;
            mvalid_reg    <= 1'b0;
            ir_thr_reg    <= 10'd700;
            force_thr_reg <= 10'd1000;
            band_reg      <= 15'd2560;
            period_reg    <= 13'd7200;
            open_reg      <= 13'd500;
            close_reg     <= 13'd6000;
            step_reg      <= 16'd655;
            for (int k = 0; k < NJ; k++) begin
                sa_reg[k]    <= '0;
                sb_reg[k]    <= '0;
                hduty_reg[k] <= '0;
                hdir_reg[k]  <= tjpg_pkg::DIR_NONE;
            end
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            j_reg       <= j_next;
            last_ir_reg <= last_ir_next;
            hgrip_reg   <= hgrip_next;
            hlamp_reg   <= hlamp_next;
            mvalid_reg  <= mvalid_next;
            for (int k = 0; k < NJ; k++) begin
                sa_reg[k]    <= sa_next[k];
                sb_reg[k]    <= sb_next[k];
                hduty_reg[k] <= hduty_next[k];
                hdir_reg[k]  <= hdir_next[k];
            end
            // register writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    tjpg_pkg::REG_IR_THR:    ir_thr_reg    <= cfg_data[9:0];
                    tjpg_pkg::REG_FORCE_THR: force_thr_reg <= cfg_data[9:0];
                    tjpg_pkg::REG_BAND:      band_reg      <= cfg_data[14:0];
                    tjpg_pkg::REG_PERIOD:    period_reg    <= cfg_data[12:0];
                    tjpg_pkg::REG_OPEN:      open_reg      <= cfg_data[12:0];
                    tjpg_pkg::REG_CLOSE:     close_reg     <= cfg_data[12:0];
                    tjpg_pkg::REG_STEP:      step_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: hw/rtl/tjpg_smul.sv
module tjpg_smul (
    input  logic               aclk,
    input  logic               aresetn,
    input  tjpg_pkg::mul_req_t req,
    output tjpg_pkg::mul_rsp_t rsp
);

    logic [tjpg_pkg::PW-1:0]  p_reg, p_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic                     run_reg, run_next;
    logic                     done_reg, done_next;
    logic [tjpg_pkg::MCW:0]   part;

    // add the multiplicand when the low multiplier bit is set
    assign part = {1'b0, p_reg[tjpg_pkg::PW-1:tjpg_pkg::MPW]}
                + (p_reg[0] ? {1'b0, req.mcand} : '0);

    always_comb begin
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start) begin
            p_next   = {{tjpg_pkg::MCW{1'b0}}, req.mplier};
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            p_next   = {part, p_reg[tjpg_pkg::MPW-1:1]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(tjpg_pkg::MPW - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg   <= p_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = p_reg;

endmodule
